@@ rtl/plsd_pkg.sv @@
// types, constants and the hex digit decoder shared by the deframer
package plsd_pkg;

    localparam int unsigned HEADER_DIGITS = 4;
    localparam logic [1:0]  HDR_LAST      = 2'(HEADER_DIGITS - 1);
    localparam logic [15:0] HDR_LEN       = 16'(HEADER_DIGITS);

    localparam logic [15:0] MAX_LEN_RESET = 16'd65520;
    localparam logic        SIDEBAND_RESET = 1'b1;

    localparam logic [1:0]  BAND_DATA = 2'd1;
    localparam logic [1:0]  BAND_MSG  = 2'd2;
    localparam logic [1:0]  BAND_RAW  = 2'd0;

    // configuration register indexes
    typedef enum logic {
        CFG_MAX_LEN  = 1'b0,
        CFG_SIDEBAND = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BAND    = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FLUSH = 2'd1,
        KIND_MSG   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_HEX  = 3'd1,
        ERR_BAD_LEN  = 3'd2,
        ERR_HUNG_UP  = 3'd3,
        ERR_BAD_BAND = 3'd4
    } t_err;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // ascii hex digit, either case
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ rtl/pkt_line_sideband_deframer.sv @@
// length-prefixed packet deframer with side-band demultiplexing
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready     | i_byte_value, i_stream_closed
//  out     | from block| o_out_valid / i_out_ready   | o_kind, o_byte_out, o_last, o_error_code
//  cfg     | to block  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  one item per cycle unless the output stalls: each accepted byte updates the header/length
//  state and loads the result register, if it yields one, in the cycle it is accepted
//  o_in_ready is low only while a held result is not taken; the result register is the
//  only stage, so the input stalls exactly when the output stalls
//  synchronous active-low reset restores the register defaults and the header phase
//  after any error the block takes items but gives no more results until reset
module pkt_line_sideband_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_stream_closed,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_out,
    output logic        o_last,
    output logic [2:0]  o_error_code,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  plsd_pkg::t_cfg_idx i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import plsd_pkg::*;

    logic [15:0] r_max_len;
    logic        r_sideband;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_accum, n_accum;
    logic [15:0] r_left, n_left;
    logic [1:0]  r_band, n_band;
    logic        r_stopped, n_stopped;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    logic        r_last;
    t_err        r_err;

    logic        n_emit;
    t_kind       n_kind;
    logic [7:0]  n_byte;
    logic        n_last;
    t_err        n_err;

    logic        in_acc;
    logic        at_boundary;
    t_hex        hex;
    logic [15:0] hdr_len;
    logic [15:0] pay_len;
    logic        len_short;
    logic        len_too_big;
    logic        len_flush;
    logic [15:0] left_dec;
    logic        band_ok;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign at_boundary = (r_phase == PH_HEADER) && (r_hdr_cnt == 2'd0);
    assign hex         = hex_decode(i_byte_value);
    assign hdr_len     = {r_accum[11:0], hex.value};
    assign pay_len     = hdr_len - HDR_LEN;
    assign len_short   = (hdr_len != 16'd0) && (hdr_len < HDR_LEN);
    assign len_too_big = !len_short && (hdr_len != 16'd0) && (pay_len >= r_max_len);
    assign len_flush   = (hdr_len == 16'd0) || (hdr_len == HDR_LEN);
    assign left_dec    = r_left - 16'd1;
    assign band_ok     = (i_byte_value == {6'd0, BAND_DATA})
                      || (i_byte_value == {6'd0, BAND_MSG});

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_accum   = r_accum;
        n_left    = r_left;
        n_band    = r_band;
        n_stopped = r_stopped;
        if (in_acc && !r_stopped) begin
            if (i_stream_closed) begin
                if (!at_boundary) begin
                    n_stopped = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (!hex.ok) begin
                            n_stopped = 1'b1;
                        end else if (r_hdr_cnt != HDR_LAST) begin
                            n_hdr_cnt = r_hdr_cnt + 2'd1;
                            n_accum   = hdr_len;
                        end else begin
                            n_hdr_cnt = 2'd0;
                            n_accum   = 16'd0;
                            if (len_short || len_too_big) begin
                                n_stopped = 1'b1;
                            end else if (!len_flush) begin
                                n_left = pay_len;
                                if (r_sideband) begin
                                    n_phase = PH_BAND;
                                end else begin
                                    n_band  = BAND_RAW;
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_BAND: begin
                        n_left = left_dec;
                        if (!band_ok) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_band  = i_byte_value[1:0];
                            n_phase = (left_dec == 16'd0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_left = left_dec;
                        if (left_dec == 16'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // result for the item
    always_comb begin
        n_emit = 1'b0;
        n_kind = KIND_FLUSH;
        n_byte = 8'd0;
        n_last = 1'b0;
        n_err  = ERR_NONE;
        if (!r_stopped) begin
            if (i_stream_closed) begin
                if (!at_boundary) begin
                    n_emit = 1'b1;
                    n_kind = KIND_ERR;
                    n_err  = ERR_HUNG_UP;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (!hex.ok) begin
                            n_emit = 1'b1;
                            n_kind = KIND_ERR;
                            n_err  = ERR_BAD_HEX;
                        end else if (r_hdr_cnt == HDR_LAST) begin
                            if (len_short || len_too_big) begin
                                n_emit = 1'b1;
                                n_kind = KIND_ERR;
                                n_err  = ERR_BAD_LEN;
                            end else if (len_flush) begin
                                n_emit = 1'b1;
                            end
                        end
                    end
                    PH_BAND: begin
                        if (!band_ok) begin
                            n_emit = 1'b1;
                            n_kind = KIND_ERR;
                            n_err  = ERR_BAD_BAND;
                        end else if (left_dec == 16'd0
                                     && i_byte_value[1:0] == BAND_DATA) begin
                            // empty data packet marks end of data
                            n_emit = 1'b1;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_emit = 1'b1;
                        n_kind = (r_band == BAND_MSG) ? KIND_MSG : KIND_DATA;
                        n_byte = i_byte_value;
                        n_last = (left_dec == 16'd0);
                    end
                    default: begin
                        n_emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_sideband  <= SIDEBAND_RESET;
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= 2'd0;
            r_accum     <= 16'd0;
            r_left      <= 16'd0;
            r_band      <= BAND_RAW;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_LEN:  r_max_len  <= i_cfg_data;
                    CFG_SIDEBAND: r_sideband <= i_cfg_data[0];
                    default:      r_sideband <= r_sideband;
                endcase
            end
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_band    <= n_band;
            r_stopped <= n_stopped;
            if (in_acc) begin
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_last <= n_last;
            r_err  <= n_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_byte_out   = r_byte;
    assign o_last       = r_last;
    assign o_error_code = r_err;

`ifndef SYNTHESIS
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_quiet_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !o_out_valid) |=> !o_out_valid)
        else $error("result after the block stopped");

    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ERR) |-> (r_stopped && o_error_code != ERR_NONE))
        else $error("error item without stop or code");

    a_code_only_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_ERR) |-> (o_error_code == ERR_NONE))
        else $error("error code on a non-error item");

    a_last_on_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_kind == KIND_DATA || o_kind == KIND_MSG))
        else $error("last flag on a non-payload item");
`endif

endmodule
